// File: rtl/core/ordered_list_engine_defines.svh
`ifndef ORDERED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_DEFINES_SVH

// Whenever ante holds in a cycle, cons must hold in the same cycle.
`define OLST_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Whenever ante holds in a cycle, cons must hold in the next cycle.
`define OLST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/olst_pkg.sv
`default_nettype none

package olst_pkg;

  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  localparam int CAPACITY_DEFAULT = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_SEARCH   = 3'd0,
    MODE_INS_HEAD = 3'd1,
    MODE_INS_AT   = 3'd2,
    MODE_INS_END  = 3'd3,
    MODE_DEL_HEAD = 3'd4,
    MODE_DEL_VAL  = 3'd5,
    MODE_DEL_END  = 3'd6
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_BADPOS   = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXEC
  } state_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;      // open a gap at the insert index and load the key there
    logic del_at;   // close the gap at a fixed index
    logic del_val;  // close the gap at the first matching cell
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/olst_if.sv
`default_nettype none

interface olst_cmd_if;
  logic                valid;
  logic                ready;
  logic [2:0]          mode;
  logic signed [31:0]  entry_value;
  logic [4:0]          position;

  modport source (output valid, output mode, output entry_value, output position,
                  input ready);
  modport sink   (input valid, input mode, input entry_value, input position,
                  output ready);
endinterface

interface olst_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [4:0] found_position;
  logic [4:0] entry_count;

  modport source (output valid, output status, output found_position, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input found_position, input entry_count,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/olst_cell.sv
`default_nettype none

module olst_cell #(
  parameter int IDX_W = 4,
  parameter int INDEX = 0
) (
  input  wire logic                clk,
  input  wire logic                cmp_en,
  input  wire logic                live,
  input  wire logic signed [31:0]  key,
  input  wire olst_pkg::cell_ctl_t ctl,
  input  wire logic [IDX_W-1:0]    at_idx,
  input  wire logic signed [31:0]  left_value,
  input  wire logic signed [31:0]  right_value,
  input  wire logic                seen_in,
  output logic signed [31:0]       value,
  output logic                     seen_out,
  output logic                     first
);
  import olst_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic match;

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      match <= live && (value == key);
    end
    if (ctl.ins) begin
      if (MY_IDX > at_idx) begin
        value <= left_value;
      end else if (MY_IDX == at_idx) begin
        value <= key;
      end
    end else if (ctl.del_at) begin
      if (MY_IDX >= at_idx) begin
        value <= right_value;
      end
    end else if (ctl.del_val) begin
      // cells at and behind the first match pull from the right
      if (seen_in || match) begin
        value <= right_value;
      end
    end
  end

  assign seen_out = seen_in || match;
  assign first    = match && !seen_in;

endmodule

`default_nettype wire

// File: rtl/core/ordered_list_engine.sv
// Ordered list engine: an ordered list of up to CAPACITY signed 32-bit values,
// held in a chain of cells, head in cell 0.
// cmd channel (valid/ready): mode, entry_value, position. One request is taken
// when valid and ready are high at a rising edge.
// res channel (valid/ready): status, found_position, entry_count, one result
// per request, in request order.
// Each request runs through accept, compare (every cell registers its
// own equality bit against the key), execute (cells shift left or right by
// one where an insert or delete needs it, and the result is loaded into the
// output register). The result shows on res right after the execute edge and
// can be taken at the next edge; a new request is taken only once the last
// one has executed.
// When res stalls, a finished result waits in the output register while the
// next request is accepted and compared; its execute step holds until the
// output register is free.
// Reset (rst, synchronous) empties the list and drops any result; cell
// contents are not cleared and are read only after being written.
`default_nettype none

`include "ordered_list_engine_defines.svh"

module ordered_list_engine #(
  parameter int CAPACITY = olst_pkg::CAPACITY_DEFAULT
) (
  input wire logic clk,
  input wire logic rst,
  olst_cmd_if.sink   cmd,
  olst_res_if.source res
);
  import olst_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam int CW    = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

  state_t state, state_next;

  logic [MODE_W-1:0]         c_mode;
  logic signed [VALUE_W-1:0] c_value;
  logic [POS_W-1:0]          c_pos;
  logic [LEN_W-1:0]          len, len_next;

  logic                  res_valid;
  logic [STATUS_W-1:0]   res_status;
  logic [POS_W-1:0]      res_found;
  logic [COUNT_W-1:0]    res_count;

  logic      accept, cmp_en, go;
  cell_ctl_t ctl, ctl_exec;
  logic [IDX_W-1:0] at_idx;

  logic signed [VALUE_W-1:0] vals [CAPACITY];
  logic [CAPACITY:0]         seen;
  logic [CAPACITY-1:0]       first;
  logic [CAPACITY-1:0]       live;

  status_t         status_exec;
  logic [CW-1:0]   found_w, found_exec;
  logic [CW-1:0]   pos_w, len_w, pos_m1, count_w;
  logic            full, empty, any_hit, bad_pos;

  // cell chain
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign live[i] = LEN_W'(i) < len;
    olst_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk         (clk),
      .cmp_en      (cmp_en),
      .live        (live[i]),
      .key         (c_value),
      .ctl         (ctl),
      .at_idx      (at_idx),
      .left_value  ((i == 0) ? c_value : vals[(i == 0) ? 0 : i - 1]),
      .right_value ((i == CAPACITY - 1) ? vals[i] : vals[(i == CAPACITY - 1) ? i : i + 1]),
      .seen_in     (seen[i]),
      .value       (vals[i]),
      .seen_out    (seen[i+1]),
      .first       (first[i])
    );
  end

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    accept     = 1'b0;
    cmp_en     = 1'b0;
    go         = 1'b0;
    case (state)
      ST_IDLE: begin
        accept = cmd.valid;
        if (cmd.valid) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        cmp_en     = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        // hold until the output register is free
        if (!res_valid || res.ready) begin
          go         = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign cmd.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (accept) begin
      c_mode  <= cmd.mode;
      c_value <= cmd.entry_value;
      c_pos   <= cmd.position;
    end
  end

  // execute decode
  always_comb begin
    found_w = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        found_w = found_w | CW'(i + 1);
      end
    end
  end

  assign full    = (len == LEN_W'(CAPACITY));
  assign empty   = (len == '0);
  assign any_hit = seen[CAPACITY];
  assign pos_w   = CW'(c_pos);
  assign len_w   = CW'(len);
  assign pos_m1  = pos_w - CW'(1);
  assign bad_pos = (pos_w == '0) || (pos_w > len_w + CW'(1));

  always_comb begin
    status_exec = STAT_OK;
    found_exec  = '0;
    ctl_exec    = '0;
    at_idx      = '0;
    len_next    = len;
    case (c_mode)
      MODE_SEARCH: begin
        if (empty) begin
          status_exec = STAT_EMPTY;
        end else if (any_hit) begin
          found_exec = found_w;
        end else begin
          status_exec = STAT_NOTFOUND;
        end
      end
      MODE_INS_HEAD: begin
        if (full) begin
          status_exec = STAT_FULL;
        end else begin
          ctl_exec.ins = 1'b1;
          len_next     = len + LEN_W'(1);
        end
      end
      MODE_INS_AT: begin
        if (full) begin
          status_exec = STAT_FULL;
        end else if (bad_pos) begin
          status_exec = STAT_BADPOS;
        end else begin
          ctl_exec.ins = 1'b1;
          at_idx       = pos_m1[IDX_W-1:0];
          len_next     = len + LEN_W'(1);
        end
      end
      MODE_INS_END: begin
        if (full) begin
          status_exec = STAT_FULL;
        end else begin
          ctl_exec.ins = 1'b1;
          at_idx       = len[IDX_W-1:0];
          len_next     = len + LEN_W'(1);
        end
      end
      MODE_DEL_HEAD: begin
        if (empty) begin
          status_exec = STAT_EMPTY;
        end else begin
          ctl_exec.del_at = 1'b1;
          len_next        = len - LEN_W'(1);
        end
      end
      MODE_DEL_VAL: begin
        if (empty) begin
          status_exec = STAT_EMPTY;
        end else if (any_hit) begin
          ctl_exec.del_val = 1'b1;
          len_next         = len - LEN_W'(1);
        end else begin
          status_exec = STAT_NOTFOUND;
        end
      end
      MODE_DEL_END: begin
        if (empty) begin
          status_exec = STAT_EMPTY;
        end else begin
          len_next = len - LEN_W'(1);
        end
      end
      default: begin
        status_exec = STAT_OK;
      end
    endcase
  end

  assign ctl     = go ? ctl_exec : '0;
  assign count_w = CW'(len_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (go) begin
        len       <= len_next;
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_status <= status_exec;
      res_found  <= found_exec[POS_W-1:0];
      res_count  <= count_w[COUNT_W-1:0];
    end
  end

  assign res.valid          = res_valid;
  assign res.status         = res_status;
  assign res.found_position = res_found;
  assign res.entry_count    = res_count;

  `OLST_ASSERT_SAME(a_len_cap, clk, rst, 1'b1, len <= LEN_W'(CAPACITY), "list length above capacity")
  `OLST_ASSERT_NEXT(a_accept_cmp, clk, rst, accept, state == ST_CMP, "accepted request skipped compare")
  `OLST_ASSERT_NEXT(a_go_result, clk, rst, go, res_valid, "executed request left no result")
  `OLST_ASSERT_SAME(a_len_step, clk, rst, !$past(rst), (len == $past(len)) || (len == $past(len) + LEN_W'(1)) || (len + LEN_W'(1) == $past(len)), "list length moved by more than one")

endmodule

`default_nettype wire
